FILE: sv/lcss_pkg.sv
// lcss_pkg: shared types and constants for the longest common substring stream block
// used by lcss_cell and longest_common_substring_stream; no dependencies
package lcss_pkg;

    localparam int SYM_BITS     = 8;
    localparam int IDX_BITS     = 6;
    localparam int LEN_OUT_BITS = 7;
    localparam int POS_OUT_BITS = 32;
    localparam int CFG_BITS     = 7;

    // kind of an input beat, carried in tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEXT = 1'b1;

    typedef enum logic [1:0] {
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_lcss_state;

    // control broadcast to every column cell
    typedef struct packed {
        logic                step;
        logic                last;
        logic                shift;
        logic [SYM_BITS-1:0] sym;
    } t_lcss_ctl;

endpackage

FILE: sv/lcss_cell.sv
// lcss_cell: one column of the dp row, holding its pattern byte, run length and best run
// depends on lcss_pkg; instantiated in a chain by longest_common_substring_stream
module lcss_cell #(
    parameter int LEN_BITS = 7,
    parameter int POS_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lcss_pkg::t_lcss_ctl    i_ctl,
    input  logic                   i_load,
    input  logic                   i_col_en,
    input  logic [LEN_BITS-1:0]    i_left_run,
    input  logic [POS_BITS-1:0]    i_pos,
    input  logic [LEN_BITS-1:0]    i_next_len,
    input  logic [POS_BITS-1:0]    i_next_end,
    output logic [LEN_BITS-1:0]    o_run,
    output logic [LEN_BITS-1:0]    o_best_len,
    output logic [POS_BITS-1:0]    o_best_end
);
    import lcss_pkg::*;

    logic [SYM_BITS-1:0] r_pat;
    logic [LEN_BITS-1:0] r_run, n_run;
    logic [LEN_BITS-1:0] r_best_len, n_best_len;
    logic [POS_BITS-1:0] r_best_end, n_best_end;
    logic                w_hit;
    logic [LEN_BITS-1:0] w_val;

    assign w_hit = i_col_en && (r_pat == i_ctl.sym);
    assign w_val = w_hit ? (i_left_run + LEN_BITS'(1)) : '0;

    always_comb begin
        n_run      = r_run;
        n_best_len = r_best_len;
        n_best_end = r_best_end;
        if (i_ctl.step) begin
            n_run = i_ctl.last ? '0 : w_val;
            // strictly greater keeps the earliest text position
            if (w_val > r_best_len) begin
                n_best_len = w_val;
                n_best_end = i_pos;
            end
        end else if (i_ctl.shift) begin
            n_best_len = i_next_len;
            n_best_end = i_next_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= '0;
            r_best_len <= '0;
        end else begin
            r_run      <= n_run;
            r_best_len <= n_best_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_end <= n_best_end;
        if (i_load) begin
            r_pat <= i_ctl.sym;
        end
    end

    assign o_run      = r_run;
    assign o_best_len = r_best_len;
    assign o_best_end = r_best_end;

endmodule

FILE: sv/longest_common_substring_stream.sv
// longest_common_substring_stream: pattern vs streamed text longest common substring
// text and load beats: one per cycle while o_s_tready is high; every column cell updates
// in the same cycle; after a last text beat the input pauses (more while an older result
// waits) as the per-column bests shift out of the chain; the result is valid after that pause
// reset clears the row, bests and text position and sets pattern_length to 1;
// pattern bytes are not cleared and read as unknown until loaded
module longest_common_substring_stream #(
    parameter int MAX_PATTERN   = 64,
    parameter int TEXT_POS_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [15:0]                       i_s_tdata,  // symbol[7:0], pattern_index[13:8]
    input  logic                              i_s_tuser,  // req_type
    input  logic                              i_s_tlast,  // last_text
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [47:0]                       o_m_tdata,  // match_length[6:0],
                                                          // text_start[38:7],
                                                          // pattern_start[44:39]
    // pattern_length register
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lcss_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import lcss_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int CW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int TW = TEXT_POS_BITS;
    localparam int SW = (LW > CW) ? ((LW > IDX_BITS) ? LW : IDX_BITS)
                                  : ((CW > IDX_BITS) ? CW : IDX_BITS);

    t_lcss_state r_state, n_state;

    logic [CFG_BITS-1:0] r_pattern_length;
    logic [TW-1:0]       r_pos;
    logic [TW-1:0]       r_last_pos;
    logic [CW-1:0]       r_k;
    logic [LW-1:0]       r_acc_len;
    logic [TW-1:0]       r_acc_end;
    logic [CW-1:0]       r_acc_col;
    logic                r_out_valid;
    logic [47:0]         r_out_data;

    logic                w_beat;
    logic                w_step;
    logic                w_load;
    logic                w_last_step;
    logic                w_shift;
    logic                w_out_load;
    logic                w_take;
    logic                w_any_best;
    logic [TW-1:0]       w_age_new;
    logic [TW-1:0]       w_age_acc;
    logic [TW-1:0]       w_ts;
    logic [SW-1:0]       w_ps;
    logic [63:0]         w_ts_wide;
    logic [15:0]         w_len_wide;
    logic [47:0]         w_result;
    t_lcss_ctl           w_ctl;

    logic [LW-1:0]       w_run      [MAX_PATTERN];
    logic [LW-1:0]       w_best_len [MAX_PATTERN];
    logic [TW-1:0]       w_best_end [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_nz;

    assign w_beat      = i_s_tvalid && o_s_tready;
    assign w_step      = w_beat && (i_s_tuser == REQ_TEXT);
    assign w_load      = w_beat && (i_s_tuser == REQ_LOAD);
    assign w_last_step = w_step && i_s_tlast;

    assign w_ctl.step  = w_step;
    assign w_ctl.last  = i_s_tlast;
    assign w_ctl.shift = w_shift;
    assign w_ctl.sym   = i_s_tdata[SYM_BITS-1:0];

    // column chain
    for (genvar c = 0; c < MAX_PATTERN; c++) begin : g_col
        logic          w_col_en;
        logic          w_col_load;
        logic [LW-1:0] w_left;
        logic [LW-1:0] w_next_len;
        logic [TW-1:0] w_next_end;

        assign w_col_en   = int'(r_pattern_length) > c;
        assign w_col_load = w_load && (int'(i_s_tdata[SYM_BITS +: IDX_BITS]) == c);

        if (c == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner
            assign w_left = w_run[c-1];
        end

        if (c == MAX_PATTERN - 1) begin : g_tail
            assign w_next_len = '0;
            assign w_next_end = '0;
        end else begin : g_body
            assign w_next_len = w_best_len[c+1];
            assign w_next_end = w_best_end[c+1];
        end

        lcss_cell #(
            .LEN_BITS (LW),
            .POS_BITS (TW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_load     (w_col_load),
            .i_col_en   (w_col_en),
            .i_left_run (w_left),
            .i_pos      (r_pos),
            .i_next_len (w_next_len),
            .i_next_end (w_next_end),
            .o_run      (w_run[c]),
            .o_best_len (w_best_len[c]),
            .o_best_end (w_best_end[c])
        );

        assign w_nz[c] = (w_best_len[c] != '0);
    end

    assign w_any_best = |w_nz;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (w_last_step) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_k == CW'(MAX_PATTERN - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_load) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_shift    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_RUN:    o_s_tready = 1'b1;
            S_DRAIN:  w_shift    = 1'b1;
            S_FINISH: w_out_load = !r_out_valid || i_m_tready;
            default:  o_s_tready = 1'b0;
        endcase
    end

    // collector: longest wins, then earliest text end, then lowest column
    assign w_age_new = r_last_pos - w_best_end[0];
    assign w_age_acc = r_last_pos - r_acc_end;
    assign w_take    = (w_best_len[0] > r_acc_len) ||
                       ((w_best_len[0] == r_acc_len) && (r_acc_len != '0) &&
                        (w_age_new > w_age_acc));

    assign w_ts       = r_acc_end - TW'(r_acc_len) + TW'(1);
    assign w_ps       = SW'(r_acc_col) - SW'(r_acc_len) + SW'(1);
    assign w_ts_wide  = 64'(w_ts);
    assign w_len_wide = 16'(r_acc_len);

    always_comb begin
        w_result = '0;
        if (r_acc_len != '0) begin
            w_result[LEN_OUT_BITS-1:0]                                   =
                w_len_wide[LEN_OUT_BITS-1:0];
            w_result[LEN_OUT_BITS +: POS_OUT_BITS]                      =
                w_ts_wide[POS_OUT_BITS-1:0];
            w_result[LEN_OUT_BITS + POS_OUT_BITS +: IDX_BITS]            =
                w_ps[IDX_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_RUN;
            r_pattern_length <= CFG_BITS'(1);
            r_pos            <= '0;
            r_k              <= '0;
            r_acc_len        <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pattern_length <= i_cfg_data;
            end
            if (w_step) begin
                r_pos <= i_s_tlast ? '0 : (r_pos + TW'(1));
            end
            if (w_last_step) begin
                r_k       <= '0;
                r_acc_len <= '0;
            end else if (w_shift) begin
                r_k <= r_k + CW'(1);
                if (w_take) begin
                    r_acc_len <= w_best_len[0];
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last_step) begin
            r_last_pos <= r_pos;
        end
        if (w_shift && w_take) begin
            r_acc_end <= w_best_end[0];
            r_acc_col <= r_k;
        end
        if (w_out_load) begin
            r_out_data <= w_result;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // a last text beat always starts the sweep
    a_last_starts_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_step |=> (r_state == S_DRAIN && r_k == '0))
        else $error("sweep did not start after last text beat");

    // the sweep only begins right after a last text beat
    a_drain_origin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && r_k == '0) |-> $past(w_last_step))
        else $error("sweep started without a last text beat");

    // after the sweep the chain holds no stale best runs
    a_chain_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> !w_any_best)
        else $error("cell bests not cleared by the sweep");

    // no match reports zero starts
    a_no_match_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[LEN_OUT_BITS-1:0] == '0) |->
        (o_m_tdata[47:LEN_OUT_BITS] == '0))
        else $error("nonzero start reported with zero length");

endmodule
